// ----- rtl/expiring_ip_session_table_macros.svh -----
// assertion macros shared by the session table checker
`ifndef EXPIRING_IP_SESSION_TABLE_MACROS_SVH
`define EXPIRING_IP_SESSION_TABLE_MACROS_SVH

// checked only outside reset
`define IPST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked through reset as well
`define IPST_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/ipst_pkg.sv -----
// types, constants and helpers of the expiring ip session table
`default_nettype none

package ipst_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CHECK = 2'd1,
        OP_TAKE  = 2'd2,
        OP_NONE  = 2'd3
    } op_code_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] session;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_PULL,
        CELL_PARK
    } cell_op_t;

    typedef enum logic [1:0] {
        CHAIN_IDLE,
        CHAIN_ADD,
        CHAIN_SCAN
    } chain_mode_t;

    typedef struct packed {
        chain_mode_t mode;
        idx_t        bound;
    } chain_ctl_t;

    // age wraps modulo 2^32
    function automatic logic is_live(input logic [31:0] stamp,
                                     input logic [31:0] now,
                                     input logic [31:0] timeout);
        logic [31:0] age;
        age = now - stamp;
        return age <= timeout;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/expiring_ip_session_table.sv -----
// add: result registered, held on a stall; one add per cycle while s_ready is high
// check/take: the scan passes every cell and registers the result at its last step;
// s_ready is low until then; the row rotates once through the head while it compacts
// a stalled output keeps one result and one more waits in a holding stage, then s_ready drops
// reset (synchronous, active low): all cells empty, timeout 1000, no result held, not ready
// a timeout write lands even while reset is held
`default_nettype none

module expiring_ip_session_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [31:0] s_ip_address,
    input  wire logic [31:0] s_session_id,
    input  wire logic [31:0] s_now_ticks,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [31:0]      m_session_out,
    output logic             m_evicted
);

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t          state_reg;
    ipst_pkg::idx_t  cnt_reg;
    ipst_pkg::idx_t  bound_reg;
    logic            hit_reg;
    logic            take_reg;
    logic [31:0]     ip_reg;
    logic [31:0]     now_reg;
    logic [31:0]     sess_reg;
    logic [31:0]     timeout_reg;
    logic            pend_valid_reg;
    logic            pend_found_reg;
    logic [31:0]     pend_session_reg;
    logic            pend_evicted_reg;
    logic            m_valid_reg;
    logic            m_found_reg;
    logic [31:0]     m_session_reg;
    logic            m_evicted_reg;

    ipst_pkg::chain_ctl_t chain_ctl;
    ipst_pkg::entry_t     new_entry;
    ipst_pkg::entry_t     park_entry;
    ipst_pkg::entry_t     head_entry;
    ipst_pkg::entry_t     tail_entry;

    logic        s_fire;
    logic        op_add;
    logic        op_lookup;
    logic        head_live;
    logic        head_match;
    logic        head_hit;
    logic        keep;
    logic        evict_now;
    logic        out_free;
    logic        res_done;
    logic        res_found;
    logic [31:0] res_session;
    logic        res_evicted;

    assign s_ready   = aresetn && (state_reg == ST_IDLE) && !pend_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign op_add    = (s_operation == ipst_pkg::OP_ADD);
    assign op_lookup = (s_operation == ipst_pkg::OP_CHECK) ||
                       (s_operation == ipst_pkg::OP_TAKE);

    assign head_live  = ipst_pkg::is_live(head_entry.stamp, now_reg, timeout_reg);
    assign head_match = (head_entry.address == ip_reg);
    assign head_hit   = !hit_reg && head_entry.valid && head_live && head_match;
    // expired cells before the first hit are freed, a taken hit is removed
    assign keep = head_entry.valid &&
                  (hit_reg || (head_live && !(head_match && take_reg)));

    always_comb begin
        park_entry       = head_entry;
        park_entry.valid = keep;
    end

    assign evict_now = tail_entry.valid &&
                       ipst_pkg::is_live(tail_entry.stamp, s_now_ticks, timeout_reg);

    assign new_entry = '{valid: 1'b1, address: s_ip_address,
                         session: s_session_id, stamp: s_now_ticks};

    always_comb begin
        chain_ctl.bound = bound_reg;
        if (state_reg == ST_SCAN) begin
            chain_ctl.mode = ipst_pkg::CHAIN_SCAN;
        end else if (s_fire && op_add) begin
            chain_ctl.mode = ipst_pkg::CHAIN_ADD;
        end else begin
            chain_ctl.mode = ipst_pkg::CHAIN_IDLE;
        end
    end

    ipst_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (chain_ctl),
        .new_entry  (new_entry),
        .park_entry (park_entry),
        .head_entry (head_entry),
        .tail_entry (tail_entry)
    );

    // result finishing this cycle: add or unused code at request, lookup at last step
    always_comb begin
        res_done    = 1'b0;
        res_found   = 1'b0;
        res_session = '0;
        res_evicted = 1'b0;
        if (state_reg == ST_SCAN) begin
            res_done  = (cnt_reg == '0);
            res_found = hit_reg || head_hit;
            if (take_reg && head_hit) begin
                res_session = head_entry.session;
            end else begin
                res_session = sess_reg;
            end
        end else if (s_fire && !op_lookup) begin
            res_done    = 1'b1;
            res_evicted = op_add && evict_now;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end else if (!aresetn) begin
            timeout_reg <= ipst_pkg::TIMEOUT_RESET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg    <= pend_valid_reg || res_done;
                pend_valid_reg <= 1'b0;
                if (pend_valid_reg) begin
                    m_found_reg   <= pend_found_reg;
                    m_session_reg <= pend_session_reg;
                    m_evicted_reg <= pend_evicted_reg;
                end else begin
                    m_found_reg   <= res_found;
                    m_session_reg <= res_session;
                    m_evicted_reg <= res_evicted;
                end
            end else if (res_done) begin
                pend_valid_reg   <= 1'b1;
                pend_found_reg   <= res_found;
                pend_session_reg <= res_session;
                pend_evicted_reg <= res_evicted;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && op_lookup) begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= ipst_pkg::idx_t'(ipst_pkg::ENTRIES - 1);
                        bound_reg <= ipst_pkg::idx_t'(ipst_pkg::ENTRIES - 1);
                        hit_reg   <= 1'b0;
                        take_reg  <= (s_operation == ipst_pkg::OP_TAKE);
                        ip_reg    <= s_ip_address;
                        now_reg   <= s_now_ticks;
                        sess_reg  <= '0;
                    end
                end
                ST_SCAN: begin
                    if (head_hit) begin
                        hit_reg <= 1'b1;
                        if (take_reg) begin
                            sess_reg <= head_entry.session;
                        end
                    end
                    if (!keep) begin
                        bound_reg <= bound_reg - 1'b1;
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_session_out = m_session_reg;
    assign m_evicted     = m_evicted_reg;

endmodule

`default_nettype wire

// ----- rtl/ipst_cell.sv -----
// one table cell: holds an entry and loads from a neighbor or the scan head
`default_nettype none

module ipst_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ipst_pkg::cell_op_t cmd,
    input  wire ipst_pkg::entry_t  prev_entry,
    input  wire ipst_pkg::entry_t  next_entry,
    input  wire ipst_pkg::entry_t  park_entry,
    output ipst_pkg::entry_t       cell_entry
);

    logic        valid_reg;
    logic [31:0] address_reg;
    logic [31:0] session_reg;
    logic [31:0] stamp_reg;

    ipst_pkg::entry_t entry_next;

    assign cell_entry = '{valid: valid_reg, address: address_reg,
                          session: session_reg, stamp: stamp_reg};

    always_comb begin
        case (cmd)
            ipst_pkg::CELL_PUSH: entry_next = prev_entry;
            ipst_pkg::CELL_PULL: entry_next = next_entry;
            ipst_pkg::CELL_PARK: entry_next = park_entry;
            default:             entry_next = cell_entry;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        address_reg <= entry_next.address;
        session_reg <= entry_next.session;
        stamp_reg   <= entry_next.stamp;
    end

endmodule

`default_nettype wire

// ----- rtl/ipst_chain.sv -----
// row of table cells, newest at cell 0, with per-cell move control
`default_nettype none

module ipst_chain (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ipst_pkg::chain_ctl_t ctl,
    input  wire ipst_pkg::entry_t     new_entry,
    input  wire ipst_pkg::entry_t     park_entry,
    output ipst_pkg::entry_t          head_entry,
    output ipst_pkg::entry_t          tail_entry
);

    ipst_pkg::entry_t   cells    [ipst_pkg::ENTRIES];
    ipst_pkg::cell_op_t cell_cmd [ipst_pkg::ENTRIES];

    // during a scan, cells below the boundary shift toward the head,
    // the boundary cell takes the entry leaving the head, the rest hold
    always_comb begin
        for (int i = 0; i < ipst_pkg::ENTRIES; i++) begin
            case (ctl.mode)
                ipst_pkg::CHAIN_ADD: cell_cmd[i] = ipst_pkg::CELL_PUSH;
                ipst_pkg::CHAIN_SCAN: begin
                    if (ipst_pkg::idx_t'(i) < ctl.bound) begin
                        cell_cmd[i] = ipst_pkg::CELL_PULL;
                    end else if (ipst_pkg::idx_t'(i) == ctl.bound) begin
                        cell_cmd[i] = ipst_pkg::CELL_PARK;
                    end else begin
                        cell_cmd[i] = ipst_pkg::CELL_HOLD;
                    end
                end
                default: cell_cmd[i] = ipst_pkg::CELL_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < ipst_pkg::ENTRIES; g++) begin : g_cell
        ipst_pkg::entry_t prev_e;
        ipst_pkg::entry_t next_e;

        if (g == 0) begin : g_first
            assign prev_e = new_entry;
        end else begin : g_mid
            assign prev_e = cells[g-1];
        end

        if (g == ipst_pkg::ENTRIES - 1) begin : g_last
            assign next_e = '0;
        end else begin : g_inner
            assign next_e = cells[g+1];
        end

        ipst_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cell_cmd[g]),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .park_entry (park_entry),
            .cell_entry (cells[g])
        );
    end

    assign head_entry = cells[0];
    assign tail_entry = cells[ipst_pkg::ENTRIES-1];

endmodule

`default_nettype wire

// ----- rtl/ipst_checker.sv -----
// port-level checks for the expiring ip session table, bound to the top level
`default_nettype none

`include "expiring_ip_session_table_macros.svh"

module ipst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_operation,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_found,
    input wire logic [31:0] m_session_out,
    input wire logic        m_evicted
);

    logic        lookup_fire;
    logic        match_data;
    logic [33:0] m_payload;

    assign lookup_fire = s_valid && s_ready &&
                         (s_operation == ipst_pkg::OP_CHECK ||
                          s_operation == ipst_pkg::OP_TAKE);
    assign match_data  = m_found || (m_session_out != 32'd0);
    assign m_payload   = {m_found, m_session_out, m_evicted};

    // no result may appear straight out of reset
    `IPST_ASSERT_RST(a_reset_no_result, !aresetn |=> !m_valid, "result valid after reset")

    // a lookup occupies the cell row, so no request is taken right after it
    `IPST_ASSERT(a_lookup_busy, lookup_fire |=> !s_ready, "request taken during lookup")

    // eviction only comes from an add, which never reports a match
    `IPST_ASSERT(a_evict_alone, m_valid && m_evicted |-> !match_data, "evicted with match data")

    `IPST_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload), "stalled result changed")

endmodule

bind expiring_ip_session_table ipst_checker u_ipst_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the expiring ip session table: directed and random requests, scoreboard check
`timescale 1ns / 100ps

module tb_top;
    import ipst_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          LONG_HOLD    = 300;
    localparam int          LAST         = ENTRIES - 1;

    typedef struct {
        logic        found;
        logic [31:0] session;
        logic        evicted;
    } session_reply_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [31:0] cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation   = '0;
    logic [31:0] s_ip_address  = '0;
    logic [31:0] s_session_id  = '0;
    logic [31:0] s_now_ticks   = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_found;
    logic [31:0] m_session_out;
    logic        m_evicted;

    expiring_ip_session_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_ip_address  (s_ip_address),
        .s_session_id  (s_session_id),
        .s_now_ticks   (s_now_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_session_out (m_session_out),
        .m_evicted     (m_evicted)
    );

    // predicted table, newest entry in slot 0
    logic [31:0]    tbl_addr  [ENTRIES];
    logic [31:0]    tbl_sess  [ENTRIES];
    logic [31:0]    tbl_stamp [ENTRIES];
    logic           tbl_used  [ENTRIES];
    logic [31:0]    lifetime;

    session_reply_t pending_replies[$];
    session_reply_t head_reply;
    int             error_count   = 0;
    int             results_seen  = 0;
    int             hit_count     = 0;
    int             evict_count   = 0;
    int             cycle_count   = 0;
    bit             source_steady = 1'b0;
    bit             sink_steady   = 1'b0;
    bit             hold_request  = 1'b0;
    logic [31:0]    clock_now     = '0;
    logic [31:0]    addr_pool [6];

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    function automatic logic fresh(input int slot, input logic [31:0] now);
        logic [31:0] age;
        age = now - tbl_stamp[slot];
        return age <= lifetime;
    endfunction

    function automatic session_reply_t predict_reply(input op_code_t op,
                                                     input logic [31:0] ip,
                                                     input logic [31:0] sid,
                                                     input logic [31:0] now);
        session_reply_t r;
        int             wr;
        logic           hit;
        r   = '{found: 1'b0, session: 32'd0, evicted: 1'b0};
        wr  = 0;
        hit = 1'b0;
        case (op)
            OP_ADD: begin
                r.evicted = tbl_used[LAST] && fresh(LAST, now);
                for (int i = LAST; i > 0; i--) begin
                    tbl_addr[i]  = tbl_addr[i-1];
                    tbl_sess[i]  = tbl_sess[i-1];
                    tbl_stamp[i] = tbl_stamp[i-1];
                    tbl_used[i]  = tbl_used[i-1];
                end
                tbl_addr[0]  = ip;
                tbl_sess[0]  = sid;
                tbl_stamp[0] = now;
                tbl_used[0]  = 1'b1;
            end
            OP_CHECK, OP_TAKE: begin
                // compact the row; expired slots before the first hit drop out
                for (int rd = 0; rd < ENTRIES; rd++) begin
                    if (!tbl_used[rd]) continue;
                    if (!hit) begin
                        if (!fresh(rd, now)) continue;
                        if (tbl_addr[rd] == ip) begin
                            hit       = 1'b1;
                            r.session = tbl_sess[rd];
                            if (op == OP_TAKE) continue;
                        end
                    end
                    if (wr != rd) begin
                        tbl_addr[wr]  = tbl_addr[rd];
                        tbl_sess[wr]  = tbl_sess[rd];
                        tbl_stamp[wr] = tbl_stamp[rd];
                        tbl_used[wr]  = tbl_used[rd];
                    end
                    wr++;
                end
                for (int k = wr; k < ENTRIES; k++) tbl_used[k] = 1'b0;
                r.found = hit;
                if (op != OP_TAKE || !hit) r.session = 32'd0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // one request; valid stays high when the next one follows with no gap
    task automatic send_request(input op_code_t op, input logic [31:0] ip,
                                input logic [31:0] sid, input logic [31:0] now);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_ip_address <= ip;
        s_session_id <= sid;
        s_now_ticks  <= now;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(predict_reply(op, ip, sid, now));
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_replies();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        drain_replies();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        lifetime   = value;
    endtask

    // result sink with random stalls and an occasional long hold-off
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = sink_steady ? 0 : $urandom_range(0, 17);
            if (hold_request) begin
                stall        = stall + LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_replies.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                head_reply = pending_replies.pop_front();
                if (m_found !== head_reply.found) begin
                    $error("found: expected %0d, actual %0d", head_reply.found, m_found);
                    error_count++;
                end
                if (m_session_out !== head_reply.session) begin
                    $error("session_out: expected %h, actual %h",
                           head_reply.session, m_session_out);
                    error_count++;
                end
                if (m_evicted !== head_reply.evicted) begin
                    $error("evicted: expected %0d, actual %0d",
                           head_reply.evicted, m_evicted);
                    error_count++;
                end
                if (m_found === 1'b1) hit_count++;
                if (m_evicted === 1'b1) evict_count++;
            end
        end
    end

    // hits, misses, duplicates, aging right at the limit, unused opcode
    task automatic test_basic_ops();
        send_request(OP_TAKE,  32'h0a00_0001, 32'h0,         32'd0);
        send_request(OP_ADD,   32'h0000_0000, 32'hffff_ffff, 32'd0);
        send_request(OP_ADD,   32'hffff_ffff, 32'h0000_0000, 32'd5);
        send_request(OP_ADD,   32'h0000_0000, 32'h0000_1234, 32'd10);
        send_request(OP_CHECK, 32'h0000_0000, 32'hdead_beef, 32'd20);
        send_request(OP_TAKE,  32'h0000_0000, 32'h0,         32'd20);
        send_request(OP_TAKE,  32'h0000_0000, 32'h0,         32'd20);
        send_request(OP_CHECK, 32'h0000_0000, 32'h0,         32'd20);
        send_request(OP_NONE,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_CHECK, 32'hffff_ffff, 32'h0,         32'd1005);
        send_request(OP_CHECK, 32'hffff_ffff, 32'h0,         32'd1006);
        send_request(OP_TAKE,  32'hffff_ffff, 32'h0,         32'd1006);
    endtask

    // full table: an expired oldest entry drops silently, a live one is flagged
    task automatic test_eviction();
        write_timeout(32'd100);
        send_request(OP_ADD, 32'hc0a8_0000, 32'd1000, 32'd0);
        for (int i = 1; i < ENTRIES; i++)
            send_request(OP_ADD, 32'hc0a8_0000 + i, 32'd1000 + i, 32'd150);
        send_request(OP_ADD,   32'hc0a8_0100, 32'd2000, 32'd150);
        send_request(OP_ADD,   32'hc0a8_0101, 32'd2001, 32'd150);
        send_request(OP_CHECK, 32'hc0a8_0001, 32'd0,    32'd150);
    endtask

    // receiver holds off while requests keep coming, then the source waits it out
    task automatic test_backpressure();
        write_timeout(32'hffff_ffff);
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        hold_request  = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(op_code_t'(i % 3 == 0 ? OP_CHECK : OP_ADD),
                         32'h0a0a_0000 + (i % 5), $urandom, clock_now + i);
        drain_replies();
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        for (int i = 0; i < 10; i++)
            send_request(OP_TAKE, 32'h0a0a_0000 + (i % 5), 32'd0, clock_now + 100);
    endtask

    task automatic test_random_traffic(input int count, input logic [31:0] timeout,
                                       input int unsigned step, input bit steady_src,
                                       input bit steady_snk);
        int       roll;
        op_code_t op;
        logic [31:0] ip;
        write_timeout(timeout);
        source_steady = steady_src;
        sink_steady   = steady_snk;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hffff_ffff;
        // start close to the wrap point so ages straddle it
        clock_now = 32'hffff_ffff - $urandom_range(0, 4 * step + 10);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            op   = op_code_t'(roll < 45 ? OP_ADD : roll < 70 ? OP_CHECK :
                              roll < 95 ? OP_TAKE : OP_NONE);
            ip   = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 5)];
            if ($urandom_range(0, 24) == 0) clock_now = $urandom;
            else clock_now = clock_now + $urandom_range(0, step);
            send_request(op, ip, $urandom, clock_now);
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_addr[i]  = '0;
            tbl_sess[i]  = '0;
            tbl_stamp[i] = '0;
            tbl_used[i]  = 1'b0;
        end
        lifetime = TIMEOUT_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_eviction();
        test_backpressure();
        test_random_traffic(60,  32'd0,         1,             1'b0, 1'b0);
        test_random_traffic(100, 32'hffff_ffff, 32'h4000_0000, 1'b1, 1'b1);
        test_random_traffic(150, 32'd40,        12,            1'b0, 1'b0);
        test_random_traffic(150, 32'd1000,      150,           1'b1, 1'b0);
        test_random_traffic(100, $urandom,      32'h0100_0000, 1'b0, 1'b1);
        test_random_traffic(40,  32'd1000,      150,           1'b0, 1'b0);

        drain_replies();
        repeat (ENTRIES + 4) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $error("%0d expected results never arrived", pending_replies.size());
            error_count++;
        end
        $display("checked %0d replies over add, check, take and unused opcodes", results_seen);
        $display("%0d lookup hits, %0d live evictions, timeouts from zero to max",
                 hit_count, evict_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
